// ===== rtl/lce_pkg.sv =====
// ----------------------------------------------------------------------------
// LSTM cell element-wise package
// Shared widths, item types and the sigmoid and tanh tables.
// The tables are worked out at elaboration by the same integer series that
// defines them.
// ----------------------------------------------------------------------------
package lce_pkg;

    localparam int DATA_WIDTH       = 16;
    localparam int ACT_TABLE_POINTS = 256;
    localparam int FRAC_BITS        = DATA_WIDTH - 5;
    localparam int POS_BITS         = DATA_WIDTH - 1;
    localparam int FR_W             = POS_BITS + 1;
    localparam int IDX_W            = $clog2(ACT_TABLE_POINTS + 1);
    localparam int POS_W            = DATA_WIDTH + IDX_W;
    localparam int ACC_W            = DATA_WIDTH + FR_W + 3;
    localparam int PROD_W           = 2 * DATA_WIDTH;
    localparam int HALF_SPAN        = 1 << (DATA_WIDTH - 2);
    localparam int TAB_OFS          = 2 << FRAC_BITS;
    // The table size is a power of two, so scaling by it is a shift.
    localparam int TAB_SHIFT        = $clog2(ACT_TABLE_POINTS);
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef data_t act_tab_t [0:ACT_TABLE_POINTS];

    typedef struct packed {
        data_t pre_input_gate;
        data_t pre_forget_gate;
        data_t pre_output_gate;
        data_t pre_candidate;
        data_t rec_input_gate;
        data_t rec_forget_gate;
        data_t rec_output_gate;
        data_t rec_candidate;
        data_t cell_prev;
        logic  carry_state;
        logic  end_of_vector;
    } in_item_t;

    typedef struct packed {
        data_t act_input_gate;
        data_t act_forget_gate;
        data_t act_output_gate;
        data_t act_candidate;
        data_t cell_new;
        data_t hidden_new;
        logic  end_flag;
    } out_item_t;

    // Unsigned quotient by shift and subtract; used only to build the tables.
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-f for f in [0,1], Q30, alternating Taylor series.
    function automatic longint unsigned exp_frac(longint unsigned f);
        longint unsigned sum;
        longint unsigned term;
        sum  = ONE_Q30;
        term = ONE_Q30;
        for (int k = 1; k <= 24; k++) begin
            term = udiv((term * f) >> 30, 64'(k));
            if ((k & 1) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic longint unsigned exp_neg(longint unsigned a);
        longint unsigned n;
        longint unsigned r;
        longint unsigned e1;
        n  = a >> 30;
        r  = exp_frac(a & (ONE_Q30 - 1));
        e1 = exp_frac(ONE_Q30);
        while (n > 0) begin
            r = (r * e1) >> 30;
            n = n - 1;
        end
        return r;
    endfunction

    function automatic longint unsigned sig_q30(longint unsigned mag, bit neg);
        longint unsigned s;
        s = udiv(ONE_Q30 << 30, ONE_Q30 + exp_neg(mag));
        return neg ? ONE_Q30 - s : s;
    endfunction

    function automatic data_t q30_to_q(longint unsigned v);
        longint unsigned r;
        r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return data_t'(r);
    endfunction

    function automatic act_tab_t build_tab(bit use_tanh);
        act_tab_t        t;
        longint          d;
        longint unsigned m;
        longint unsigned s;
        bit              neg;
        data_t           q;
        for (int k = 0; k <= ACT_TABLE_POINTS; k++) begin
            d   = 2 * longint'(k) - longint'(ACT_TABLE_POINTS);
            neg = (d < 0);
            m   = longint'(neg ? -d : d);
            if (!use_tanh) begin
                t[k] = q30_to_q(sig_q30((m << 33) >> TAB_SHIFT, neg));
            end
            else begin
                s    = 2 * sig_q30((m << 34) >> TAB_SHIFT, 1'b0) - ONE_Q30;
                q    = q30_to_q(s);
                t[k] = neg ? -q : q;
            end
        end
        return t;
    endfunction

    localparam act_tab_t SIG_TAB  = build_tab(1'b0);
    localparam act_tab_t TANH_TAB = build_tab(1'b1);

endpackage

// ===== rtl/lce_gate_sum.sv =====
// ----------------------------------------------------------------------------
// Gate sum stage
// Adds the recurrent terms to the gate pre-activations with saturation when
// the carry flag is set, and registers the sums with the item's sideband.
// ----------------------------------------------------------------------------
module lce_gate_sum
    import lce_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  in_item_t item,
    output data_t    sum_i_reg,
    output data_t    sum_f_reg,
    output data_t    sum_o_reg,
    output data_t    sum_g_reg,
    output data_t    cell_prev_reg,
    output logic     carry_reg,
    output logic     eov_reg
);

    function automatic data_t sat_add(data_t a, data_t b, logic carry);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (!carry)
            return a;
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            return s[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                 : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        return s[DATA_WIDTH-1:0];
    endfunction

    data_t sum_i_next, sum_f_next, sum_o_next, sum_g_next;

    always_comb
    begin
        sum_i_next = sat_add(item.pre_input_gate,  item.rec_input_gate,  item.carry_state);
        sum_f_next = sat_add(item.pre_forget_gate, item.rec_forget_gate, item.carry_state);
        sum_o_next = sat_add(item.pre_output_gate, item.rec_output_gate, item.carry_state);
        sum_g_next = sat_add(item.pre_candidate,   item.rec_candidate,   item.carry_state);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_i_reg     <= sum_i_next;
            sum_f_reg     <= sum_f_next;
            sum_o_reg     <= sum_o_next;
            sum_g_reg     <= sum_g_next;
            cell_prev_reg <= item.cell_prev;
            carry_reg     <= item.carry_state;
            eov_reg       <= item.end_of_vector;
        end
    end

endmodule

// ===== rtl/lce_act.sv =====
// ----------------------------------------------------------------------------
// Activation unit
// Sigmoid or tanh by table lookup with linear interpolation, in two stages:
// table read, then interpolation.
// ----------------------------------------------------------------------------
module lce_act
    import lce_pkg::*;
(
    input  logic  clk,
    input  logic  en_rd,
    input  logic  en_ip,
    input  logic  use_tanh,
    input  data_t x,
    output data_t y_reg
);

    data_t                   xc;
    logic [DATA_WIDTH-1:0]   u;
    logic [POS_W-1:0]        pos;
    logic [IDX_W:0]          idx_raw;
    logic [IDX_W-1:0]        idx;
    logic [FR_W-1:0]         frac_next;
    data_t                   t0_next, t1_next;
    data_t                   t0_reg, t1_reg;
    logic [FR_W-1:0]         frac_reg;
    logic signed [DATA_WIDTH:0] b0, b1;
    logic signed [FR_W:0]    w0, w1;
    logic signed [ACC_W-1:0] acc;
    data_t                   y_next;

    always_comb
    begin
        xc = x;
        if (x < -data_t'(HALF_SPAN))
            xc = -data_t'(HALF_SPAN);
        if (x > data_t'(HALF_SPAN))
            xc = data_t'(HALF_SPAN);
        u       = DATA_WIDTH'(xc) + DATA_WIDTH'(HALF_SPAN);
        pos     = POS_W'(u) * POS_W'(ACT_TABLE_POINTS);
        idx_raw = pos[POS_W-1:POS_BITS];
        // The top end of the range interpolates fully onto the last entry.
        if (idx_raw >= (IDX_W+1)'(ACT_TABLE_POINTS))
        begin
            idx       = IDX_W'(ACT_TABLE_POINTS - 1);
            frac_next = FR_W'(1) << POS_BITS;
        end
        else
        begin
            idx       = idx_raw[IDX_W-1:0];
            frac_next = {1'b0, pos[POS_BITS-1:0]};
        end
        t0_next = use_tanh ? TANH_TAB[idx] : SIG_TAB[idx];
        t1_next = use_tanh ? TANH_TAB[idx + IDX_W'(1)] : SIG_TAB[idx + IDX_W'(1)];
    end

    always_ff @(posedge clk)
    begin
        if (en_rd)
        begin
            t0_reg   <= t0_next;
            t1_reg   <= t1_next;
            frac_reg <= frac_next;
        end
    end

    always_comb
    begin
        b0     = {t0_reg[DATA_WIDTH-1], t0_reg} + (DATA_WIDTH+1)'(TAB_OFS);
        b1     = {t1_reg[DATA_WIDTH-1], t1_reg} + (DATA_WIDTH+1)'(TAB_OFS);
        w0     = {1'b0, (FR_W'(1) << POS_BITS) - frac_reg};
        w1     = {1'b0, frac_reg};
        acc    = ACC_W'(b0) * ACC_W'(w0) + ACC_W'(b1) * ACC_W'(w1)
               + (ACC_W'(1) <<< (POS_BITS - 1));
        y_next = data_t'((acc >>> POS_BITS) - ACC_W'(TAB_OFS));
    end

    always_ff @(posedge clk)
    begin
        if (en_ip)
            y_reg <= y_next;
    end

endmodule

// ===== rtl/lce_mac.sv =====
// ----------------------------------------------------------------------------
// Product and round unit
// Computes a*b + c*d in two stages: registered products, then sum, round
// half up to the data format and saturate.
// ----------------------------------------------------------------------------
module lce_mac
    import lce_pkg::*;
(
    input  logic  clk,
    input  logic  en_mul,
    input  logic  en_rnd,
    input  data_t a,
    input  data_t b,
    input  data_t c,
    input  data_t d,
    output data_t y_reg
);

    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic signed [PROD_W:0]   sum;
    logic signed [PROD_W:0]   sh;
    data_t                    y_next;

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            p0_reg <= PROD_W'(a) * PROD_W'(b);
            p1_reg <= PROD_W'(c) * PROD_W'(d);
        end
    end

    always_comb
    begin
        sum = (PROD_W+1)'(p0_reg) + (PROD_W+1)'(p1_reg)
            + ((PROD_W+1)'(1) <<< (FRAC_BITS - 1));
        sh  = sum >>> FRAC_BITS;
        if (sh > (PROD_W+1)'(data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}})))
            y_next = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        else if (sh < (PROD_W+1)'(data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}})))
            y_next = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            y_next = sh[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_rnd)
            y_reg <= y_next;
    end

endmodule

// ===== rtl/lce_side.sv =====
// ----------------------------------------------------------------------------
// Sideband delay line
// Carries the gate activations, the new cell value and the end flag from the
// activation stage down to the output alongside the cell and hidden math.
// ----------------------------------------------------------------------------
module lce_side
    import lce_pkg::*;
(
    input  logic      clk,
    input  logic [9:4] en,
    input  out_item_t side_in,
    input  data_t     cell_val,
    output out_item_t side_out
);

    out_item_t side_reg [4:9];
    out_item_t side_next [4:9];

    always_comb
    begin
        side_next[4] = side_in;
        for (int k = 5; k <= 9; k++)
            side_next[k] = side_reg[k-1];
        side_next[6].cell_new = cell_val;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 4; k <= 9; k++)
            if (en[k])
                side_reg[k] <= side_next[k];
    end

    assign side_out = side_reg[9];

endmodule

// ===== rtl/lstm_cell_elementwise.sv =====
// ----------------------------------------------------------------------------
// LSTM cell element-wise step
// One hidden element per item: gate sums, sigmoid/tanh activations, the new
// cell and the new hidden value, all in signed Q4.11 with saturation.
// ----------------------------------------------------------------------------
// The block takes one item per clock when it is not stalled and returns one
// item per item, through gate sum, table read, interpolation, products, cell
// round, tanh table read of the cell, interpolation, product, hidden round.
// Every stage holds its own valid bit, so a stall at the result side only stops
// the stages behind a full one, and bubbles are squeezed out while it lasts.
// ----------------------------------------------------------------------------
module lstm_cell_elementwise
    import lce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_item,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_item
);

    logic [9:1]  v_reg;
    logic [9:1]  v_next;
    logic [10:1] ready;

    data_t sum_i, sum_f, sum_o, sum_g, cp1;
    logic  carry1, eov1;
    logic  carry2_reg, eov2_reg, carry3_reg, eov3_reg;
    data_t cp2_reg, cp3_reg;
    data_t act_i, act_f, act_o, act_g, act_f_m;
    data_t cell5, tanh_c, hidden;
    out_item_t side_in, side_out;

    always_comb
    begin
        ready[10] = !res_stall;
        for (int k = 9; k >= 1; k--)
            ready[k] = !v_reg[k] || ready[k+1];
        v_next[1] = src_valid;
        for (int k = 2; k <= 9; k++)
            v_next[k] = v_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 1; k <= 9; k++)
                if (ready[k])
                    v_reg[k] <= v_next[k];
        end
    end

    assign src_stall = !ready[1];

    lce_gate_sum u_sum (
        .clk           (clk),
        .en            (ready[1]),
        .item          (src_item),
        .sum_i_reg     (sum_i),
        .sum_f_reg     (sum_f),
        .sum_o_reg     (sum_o),
        .sum_g_reg     (sum_g),
        .cell_prev_reg (cp1),
        .carry_reg     (carry1),
        .eov_reg       (eov1)
    );

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            carry2_reg <= carry1;
            eov2_reg   <= eov1;
            cp2_reg    <= cp1;
        end
        if (ready[3])
        begin
            carry3_reg <= carry2_reg;
            eov3_reg   <= eov2_reg;
            cp3_reg    <= cp2_reg;
        end
    end

    lce_act u_act_i (.clk(clk), .en_rd(ready[2]), .en_ip(ready[3]), .use_tanh(1'b0),
                     .x(sum_i), .y_reg(act_i));
    lce_act u_act_f (.clk(clk), .en_rd(ready[2]), .en_ip(ready[3]), .use_tanh(1'b0),
                     .x(sum_f), .y_reg(act_f));
    lce_act u_act_o (.clk(clk), .en_rd(ready[2]), .en_ip(ready[3]), .use_tanh(1'b0),
                     .x(sum_o), .y_reg(act_o));
    lce_act u_act_g (.clk(clk), .en_rd(ready[2]), .en_ip(ready[3]), .use_tanh(1'b1),
                     .x(sum_g), .y_reg(act_g));

    // At the start of a sequence the forget gate is zero, so no old cell is kept.
    assign act_f_m = carry3_reg ? act_f : '0;

    lce_mac u_mac_cell (
        .clk    (clk),
        .en_mul (ready[4]),
        .en_rnd (ready[5]),
        .a      (act_f_m),
        .b      (cp3_reg),
        .c      (act_i),
        .d      (act_g),
        .y_reg  (cell5)
    );

    lce_act u_act_c (.clk(clk), .en_rd(ready[6]), .en_ip(ready[7]), .use_tanh(1'b1),
                     .x(cell5), .y_reg(tanh_c));

    always_comb
    begin
        side_in.act_input_gate  = act_i;
        side_in.act_forget_gate = act_f_m;
        side_in.act_output_gate = act_o;
        side_in.act_candidate   = act_g;
        side_in.cell_new        = '0;
        side_in.hidden_new      = '0;
        side_in.end_flag        = eov3_reg;
    end

    lce_side u_side (
        .clk      (clk),
        .en       (ready[9:4]),
        .side_in  (side_in),
        .cell_val (cell5),
        .side_out (side_out)
    );

    out_item_t side7;
    assign side7 = side_out;

    data_t act_o7_reg;
    always_ff @(posedge clk)
    begin
        if (ready[4]) act_o7_reg <= act_o;
    end

    data_t ao5_reg, ao6_reg, ao7_reg;
    always_ff @(posedge clk)
    begin
        if (ready[5]) ao5_reg <= act_o7_reg;
        if (ready[6]) ao6_reg <= ao5_reg;
        if (ready[7]) ao7_reg <= ao6_reg;
    end

    lce_mac u_mac_hid (
        .clk    (clk),
        .en_mul (ready[8]),
        .en_rnd (ready[9]),
        .a      (ao7_reg),
        .b      (tanh_c),
        .c      ('0),
        .d      ('0),
        .y_reg  (hidden)
    );

    always_comb
    begin
        res_item            = side7;
        res_item.hidden_new = hidden;
    end

    assign res_valid = v_reg[9];

    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (&v_reg))
        else $error("input stalled while the pipeline has an empty stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> v_reg[1])
        else $error("accepted item did not enter the first stage");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[4] && ready[5]) |=> v_reg[5])
        else $error("item lost between product and cell stages");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[8] && !ready[9]) |=> v_reg[8])
        else $error("item dropped while the output stage was held");

endmodule
